// ===== rtl/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier point evaluator package
// Shared widths, field types and the degree code of the curve evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int T_FIELD_W   = T_FRAC_BITS + 1;
  localparam int SQ_W        = 2 * T_FRAC_BITS + 1;
  localparam int W_W         = 3 * T_FRAC_BITS + 1;
  localparam int PROD_W      = W_W + 1 + COORD_BITS;
  localparam int SUM_W       = PROD_W;
  localparam int PIPE_DEPTH  = 7;

  localparam logic [T_FIELD_W-1:0] T_ONE = T_FIELD_W'(1) << T_FRAC_BITS;

  typedef enum logic [1:0] {
    DEG_POINT  = 2'd0,
    DEG_LINEAR = 2'd1,
    DEG_QUAD   = 2'd2,
    DEG_CUBIC  = 2'd3
  } degree_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [W_W-1:0]               weight_t;

  typedef struct packed {
    degree_e                degree;
    logic [T_FIELD_W-1:0]   t_frac;
    coord_t                 p0_x;
    coord_t                 p0_y;
    coord_t                 p1_x;
    coord_t                 p1_y;
    coord_t                 p2_x;
    coord_t                 p2_y;
    coord_t                 p3_x;
    coord_t                 p3_y;
  } in_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
  } out_item_t;

  typedef struct packed {
    weight_t [3:0] w;
    degree_e       degree;
  } weight_set_t;

endpackage

// ===== rtl/bpe_weights.sv =====
// ----------------------------------------------------------------------------
// Bernstein weight generator
// Three register stages that turn t and the degree into the four weights.
// ----------------------------------------------------------------------------
module bpe_weights (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  bpe_pkg::degree_e                  degree_i,
  input  logic [bpe_pkg::T_FIELD_W-1:0]     t_frac_i,
  output bpe_pkg::weight_set_t              weights_o
);

  logic [bpe_pkg::T_FIELD_W-1:0] a_d, a1_q, a2_q;
  logic [bpe_pkg::T_FIELD_W-1:0] ma_d, ma1_q, ma2_q;
  bpe_pkg::degree_e              deg1_q, deg2_q;
  logic [bpe_pkg::SQ_W-1:0]      aa_d, aa_q, mm_d, mm_q, am_d, am_q;
  logic [bpe_pkg::W_W-1:0]       mma, mmaa, aama, aaa;
  bpe_pkg::weight_set_t          weights_d, weights_q;

  always_comb begin
    a_d  = (t_frac_i > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : t_frac_i;
    ma_d = bpe_pkg::T_ONE - a_d;
  end

  always_comb begin
    aa_d = bpe_pkg::SQ_W'(a1_q) * bpe_pkg::SQ_W'(a1_q);
    mm_d = bpe_pkg::SQ_W'(ma1_q) * bpe_pkg::SQ_W'(ma1_q);
    am_d = bpe_pkg::SQ_W'(a1_q) * bpe_pkg::SQ_W'(ma1_q);
  end

  always_comb begin
    mma  = bpe_pkg::W_W'(mm_q) * bpe_pkg::W_W'(ma2_q);
    mmaa = bpe_pkg::W_W'(mm_q) * bpe_pkg::W_W'(a2_q);
    aama = bpe_pkg::W_W'(aa_q) * bpe_pkg::W_W'(ma2_q);
    aaa  = bpe_pkg::W_W'(aa_q) * bpe_pkg::W_W'(a2_q);
    weights_d.degree = deg2_q;
    weights_d.w      = '0;
    case (deg2_q)
      bpe_pkg::DEG_POINT: begin
        weights_d.w[0] = bpe_pkg::W_W'(1);
      end
      bpe_pkg::DEG_LINEAR: begin
        weights_d.w[0] = bpe_pkg::W_W'(ma2_q);
        weights_d.w[1] = bpe_pkg::W_W'(a2_q);
      end
      bpe_pkg::DEG_QUAD: begin
        weights_d.w[0] = bpe_pkg::W_W'(mm_q);
        weights_d.w[1] = bpe_pkg::W_W'({am_q, 1'b0});
        weights_d.w[2] = bpe_pkg::W_W'(aa_q);
      end
      bpe_pkg::DEG_CUBIC: begin
        weights_d.w[0] = mma;
        weights_d.w[1] = mmaa + {mmaa[bpe_pkg::W_W-2:0], 1'b0};
        weights_d.w[2] = aama + {aama[bpe_pkg::W_W-2:0], 1'b0};
        weights_d.w[3] = aaa;
      end
      default: begin
        weights_d.w = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q      <= a_d;
      ma1_q     <= ma_d;
      deg1_q    <= degree_i;
      a2_q      <= a1_q;
      ma2_q     <= ma1_q;
      deg2_q    <= deg1_q;
      aa_q      <= aa_d;
      mm_q      <= mm_d;
      am_q      <= am_d;
      weights_q <= weights_d;
    end
  end

  assign weights_o = weights_q;

endmodule

// ===== rtl/bpe_axis.sv =====
// ----------------------------------------------------------------------------
// Bezier axis accumulator
// Four register stages that weight one coordinate of the control points,
// sum the terms and divide by the scale with truncation toward zero.
// ----------------------------------------------------------------------------
module bpe_axis (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  bpe_pkg::weight_set_t      weights_i,
  input  bpe_pkg::coord_t [3:0]     pts_i,
  output bpe_pkg::coord_t           coord_o
);

  logic signed [bpe_pkg::PROD_W-1:0] term_d [4];
  logic signed [bpe_pkg::PROD_W-1:0] term_q [4];
  logic signed [bpe_pkg::SUM_W-1:0]  pair_d [2];
  logic signed [bpe_pkg::SUM_W-1:0]  pair_q [2];
  logic signed [bpe_pkg::SUM_W-1:0]  total_d, total_q;
  logic signed [bpe_pkg::SUM_W-1:0]  biased, shifted;
  logic [bpe_pkg::SUM_W-1:0]         bias;
  bpe_pkg::degree_e                  deg4_q, deg5_q, deg6_q;
  bpe_pkg::coord_t                   coord_d, coord_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term_d[i] = bpe_pkg::PROD_W'(signed'({1'b0, weights_i.w[i]}))
                * bpe_pkg::PROD_W'(pts_i[i]);
    end
    pair_d[0] = term_q[0] + term_q[1];
    pair_d[1] = term_q[2] + term_q[3];
    total_d   = pair_q[0] + pair_q[1];
  end

  always_comb begin
    bias = '0;
    case (deg6_q)
      bpe_pkg::DEG_POINT:  bias = '0;
      bpe_pkg::DEG_LINEAR: bias = (bpe_pkg::SUM_W'(1) << bpe_pkg::T_FRAC_BITS) - 1'b1;
      bpe_pkg::DEG_QUAD:   bias = (bpe_pkg::SUM_W'(1) << (2 * bpe_pkg::T_FRAC_BITS)) - 1'b1;
      bpe_pkg::DEG_CUBIC:  bias = (bpe_pkg::SUM_W'(1) << (3 * bpe_pkg::T_FRAC_BITS)) - 1'b1;
      default:             bias = '0;
    endcase
    if (!total_q[bpe_pkg::SUM_W-1]) begin
      bias = '0;
    end
    biased = total_q + signed'(bias);
    case (deg6_q)
      bpe_pkg::DEG_POINT:  shifted = biased;
      bpe_pkg::DEG_LINEAR: shifted = biased >>> bpe_pkg::T_FRAC_BITS;
      bpe_pkg::DEG_QUAD:   shifted = biased >>> (2 * bpe_pkg::T_FRAC_BITS);
      bpe_pkg::DEG_CUBIC:  shifted = biased >>> (3 * bpe_pkg::T_FRAC_BITS);
      default:             shifted = biased;
    endcase
    coord_d = shifted[bpe_pkg::COORD_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q  <= term_d;
      deg4_q  <= weights_i.degree;
      pair_q  <= pair_d;
      deg5_q  <= deg4_q;
      total_q <= total_d;
      deg6_q  <= deg5_q;
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

// ===== rtl/bezier_point_evaluator.sv =====
// ----------------------------------------------------------------------------
// Bezier point evaluator
// Evaluates one point of a Bezier curve of degree zero to three per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries a degree, a curve parameter t in 1.16 fixed
// point and four control points; each output transfer carries one curve point.
// A transfer happens at a rising edge where valid is high and stall is low.
// Values of t above one are clamped to one, and points above the degree are
// ignored. The weighted sum is exact and truncated toward zero.
// The block is a seven-stage pipeline: three stages build the Bernstein
// weights, four stages weight, sum and scale each coordinate.
// One item is accepted every cycle while the input stall is low.
// The whole pipeline advances as one. When the output is valid and the
// receiver stalls, every stage holds and the input stall goes high, so no
// item is lost or repeated.
// Reset clears all valid bits; the block keeps no state between items.
// ----------------------------------------------------------------------------
module bezier_point_evaluator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bpe_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bpe_pkg::out_item_t  out_data_o
);

  logic [bpe_pkg::PIPE_DEPTH-1:0] valid_d, valid_q;
  logic                  en;
  bpe_pkg::coord_t [3:0] px_d, px1_q, px2_q, px3_q;
  bpe_pkg::coord_t [3:0] py_d, py1_q, py2_q, py3_q;
  bpe_pkg::weight_set_t  weights;

  assign en         = !(valid_q[bpe_pkg::PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o = !en;
  assign valid_d    = {valid_q[bpe_pkg::PIPE_DEPTH-2:0], in_valid_i};

  always_comb begin
    px_d = {in_data_i.p3_x, in_data_i.p2_x, in_data_i.p1_x, in_data_i.p0_x};
    py_d = {in_data_i.p3_y, in_data_i.p2_y, in_data_i.p1_y, in_data_i.p0_y};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= px_d;
      px2_q <= px1_q;
      px3_q <= px2_q;
      py1_q <= py_d;
      py2_q <= py1_q;
      py3_q <= py2_q;
    end
  end

  bpe_weights u_weights (
    .clk_i     (clk_i),
    .en_i      (en),
    .degree_i  (in_data_i.degree),
    .t_frac_i  (in_data_i.t_frac),
    .weights_o (weights)
  );

  bpe_axis u_axis_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .weights_i (weights),
    .pts_i     (px3_q),
    .coord_o   (out_data_o.point_x)
  );

  bpe_axis u_axis_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .weights_i (weights),
    .pts_i     (py3_q),
    .coord_o   (out_data_o.point_y)
  );

  assign out_valid_o = valid_q[bpe_pkg::PIPE_DEPTH-1];

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Bezier point evaluator testbench
// Sends curve evaluations of every degree through the block and checks each
// returned point against an exact fixed-point Bernstein evaluation done here.
// A short directed set covers the ends of t, t above one, extreme points and
// truncation toward zero, then random curves follow. Both sides idle in
// random bursts, the receiver holds off once for a long stretch to fill the
// pipeline, and the sender twice waits until every point has come back.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int LONG_HOLD    = 120;

  localparam logic [bpe_pkg::T_FIELD_W-1:0] T_EDGES [5] = '{
    '0, bpe_pkg::T_ONE >> 1, bpe_pkg::T_ONE, bpe_pkg::T_ONE + 1, '1
  };

  typedef struct {
    bpe_pkg::in_item_t req;
    bit                drain_first;
  } curve_job_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  bpe_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bpe_pkg::out_item_t out_data_o;

  curve_job_t         pending_jobs [$];
  bpe_pkg::out_item_t expected_points [$];
  curve_job_t         next_job;
  bpe_pkg::out_item_t want_point;
  int         mismatches   = 0;
  int         accepted_cnt = 0;
  int         send_gap     = 0;
  int         recv_gap     = 0;
  int         hold_cnt     = 0;
  bit         hold_done    = 1'b0;
  int         cycles       = 0;

  bezier_point_evaluator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bpe_pkg::coord_t bernstein_coord(bpe_pkg::degree_e deg,
                                                      logic [bpe_pkg::T_FIELD_W-1:0] tf,
                                                      bpe_pkg::coord_t [3:0] pts);
    logic [127:0]                  pos_sum;
    logic [127:0]                  neg_sum;
    logic [127:0]                  term;
    logic [bpe_pkg::T_FIELD_W-1:0] a;
    logic [bpe_pkg::T_FIELD_W-1:0] ma;
    logic [16:0]                   mag;
    bpe_pkg::coord_t               q;
    bit                            negative;
    int                            d;
    a = (tf > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : tf;
    ma = bpe_pkg::T_ONE - a;
    d = int'(deg);
    pos_sum = '0;
    neg_sum = '0;
    for (int i = 0; i <= d; i++) begin
      term = 128'((d == 3 && (i == 1 || i == 2)) ? 3 : (d == 2 && i == 1) ? 2 : 1);
      for (int k = 0; k < d - i; k++) term = term * ma;
      for (int k = 0; k < i; k++) term = term * a;
      mag = (pts[i] < 0) ? 17'(-int'(pts[i])) : 17'(int'(pts[i]));
      term = term * mag;
      if (pts[i] < 0) begin
        neg_sum = neg_sum + term;
      end else begin
        pos_sum = pos_sum + term;
      end
    end
    negative = neg_sum > pos_sum;
    term = negative ? neg_sum - pos_sum : pos_sum - neg_sum;
    term = term >> (d * bpe_pkg::T_FRAC_BITS);
    q = term[bpe_pkg::COORD_BITS-1:0];
    return negative ? -q : q;
  endfunction

  function automatic bpe_pkg::out_item_t predict_point(bpe_pkg::in_item_t c);
    bpe_pkg::out_item_t p;
    p.point_x = bernstein_coord(c.degree, c.t_frac, {c.p3_x, c.p2_x, c.p1_x, c.p0_x});
    p.point_y = bernstein_coord(c.degree, c.t_frac, {c.p3_y, c.p2_y, c.p1_y, c.p0_y});
    return p;
  endfunction

  function automatic bpe_pkg::coord_t random_coord();
    case ($urandom_range(0, 7))
      0: return bpe_pkg::coord_t'(-32768);
      1: return bpe_pkg::coord_t'(32767);
      2: return '0;
      default: return bpe_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic bpe_pkg::in_item_t random_curve();
    bpe_pkg::in_item_t c;
    c.degree = bpe_pkg::degree_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: c.t_frac = '0;
      1: c.t_frac = bpe_pkg::T_ONE;
      2: c.t_frac = bpe_pkg::T_FIELD_W'($urandom_range(int'(bpe_pkg::T_ONE) + 1,
                                                       2 * int'(bpe_pkg::T_ONE) - 1));
      default: c.t_frac = bpe_pkg::T_FIELD_W'($urandom_range(0, int'(bpe_pkg::T_ONE)));
    endcase
    c.p0_x = random_coord();
    c.p0_y = random_coord();
    c.p1_x = random_coord();
    c.p1_y = random_coord();
    c.p2_x = random_coord();
    c.p2_y = random_coord();
    c.p3_x = random_coord();
    c.p3_y = random_coord();
    return c;
  endfunction

  function automatic bit idling_allowed();
    return pending_jobs.size() >= 150 && !(pending_jobs.size() inside {[900:1000]});
  endfunction

  task automatic queue_curve(bpe_pkg::in_item_t c, bit drain);
    curve_job_t j;
    j.req = c;
    j.drain_first = drain;
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic flag_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch on %s: expected %0d, got %0d.", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_points = {expected_points, predict_point(in_data_i)};
        accepted_cnt <= accepted_cnt + 1;
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_jobs.size() == 0 ||
                   (pending_jobs[0].drain_first && expected_points.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else if (idling_allowed() && hold_cnt == 0 && $urandom_range(0, 11) == 0) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(0, 18);
      end else begin
        next_job = pending_jobs.pop_front();
        in_valid_i <= 1'b1;
        in_data_i <= next_job.req;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (!hold_done && accepted_cnt >= 400) begin
        hold_cnt <= LONG_HOLD;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          flag_mismatch("unexpected point", 0, 1);
        end else begin
          want_point = expected_points.pop_front();
          if (out_data_o.point_x !== want_point.point_x) begin
            flag_mismatch("point_x", want_point.point_x, out_data_o.point_x);
          end
          if (out_data_o.point_y !== want_point.point_y) begin
            flag_mismatch("point_y", want_point.point_y, out_data_o.point_y);
          end
        end
      end
      if (hold_cnt != 0) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap != 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (idling_allowed() && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= $urandom_range(0, 18);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    bpe_pkg::in_item_t c;
    for (int d = 0; d < 4; d++) begin
      for (int e = 0; e < 5; e++) begin
        c = random_curve();
        c.degree = bpe_pkg::degree_e'(d);
        c.t_frac = T_EDGES[e];
        queue_curve(c, 1'b0);
      end
    end
    c = '{degree: bpe_pkg::DEG_CUBIC, t_frac: bpe_pkg::T_ONE >> 1,
          default: bpe_pkg::coord_t'(-32768)};
    queue_curve(c, 1'b0);
    c = '{degree: bpe_pkg::DEG_CUBIC, t_frac: 17'd12345,
          default: bpe_pkg::coord_t'(32767)};
    queue_curve(c, 1'b0);
    // Negative fractions must truncate toward zero, not toward minus infinity.
    c = '{degree: bpe_pkg::DEG_LINEAR, t_frac: bpe_pkg::T_ONE >> 1, default: '0};
    c.p0_x = bpe_pkg::coord_t'(-1);
    c.p0_y = bpe_pkg::coord_t'(-3);
    c.p1_y = bpe_pkg::coord_t'(-2);
    queue_curve(c, 1'b0);
    c = '{degree: bpe_pkg::DEG_QUAD, t_frac: bpe_pkg::T_ONE >> 1, default: '0};
    c.p0_x = bpe_pkg::coord_t'(-3);
    c.p2_y = bpe_pkg::coord_t'(-3);
    queue_curve(c, 1'b0);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      queue_curve(random_curve(), n == 0 || n == 700);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_jobs.size() != 0 || in_valid_i || expected_points.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bpe_pkg.sv
rtl/bpe_weights.sv
rtl/bpe_axis.sv
rtl/bezier_point_evaluator.sv
tb/sv/testbench.sv
